[rtl/core/normal_vector_color_encode_unit_assert.svh]
// Assertion macros shared by the normal vector color encoder RTL.
// Each macro expects clk and the active-low reset rst_n in scope.
`ifndef NORMAL_VECTOR_COLOR_ENCODE_UNIT_ASSERT_SVH
`define NORMAL_VECTOR_COLOR_ENCODE_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset
`define NVCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nvce assertion failed");

// Next-cycle implication
`define NVCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nvce assertion failed");

`endif

[rtl/core/nvce_pkg.sv]
// Shared types and constants for the normal vector color encoder.
// No dependencies.
package nvce_pkg;

    // Width of one color channel
    localparam int CHAN_W = 8;

    // One bit of the channel code is settled per search step
    localparam int NUM_STEPS = CHAN_W;

    // Width of the squared channel offset |2k - 256|^2 (max 254^2)
    localparam int AA2_W = 16;

    // Channel value for a zero vector and the fixed alpha
    localparam logic [CHAN_W-1:0] CHAN_MID   = 8'd128;
    localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'd255;

    // Control that travels with every pipeline stage
    typedef struct packed {
        logic valid;
        logic zero;
    } nvce_ctl_t;

    // One finished result
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              zero;
    } nvce_pix_t;

endpackage

[rtl/core/normal_vector_color_encode_unit.sv]
// Normal vector color encoder: takes a signed 3-component direction at any
// scale and returns the unit vector packed as 8-bit RGBA, each channel
// round(255*(n+1)/2) with alpha at 255; an all-zero vector gives 128 on RGB
// and sets zero_input. Accepts one request per clock and returns one result
// per request, in order: three front stages form the squared length and
// scaled squared components, then each of the eight channel bits takes three
// stages (offset square, partial products against the squared length,
// compare), and the result is then written into a two-entry output queue.
// in_ready drops only while that queue is full and a result waits at the
// pipeline tail. Depends on nvce_pkg, nvce_prep, nvce_search_step,
// nvce_out_buf and the assertion macro header.
`include "normal_vector_color_encode_unit_assert.svh"

module normal_vector_color_encode_unit #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] dir_x,
    input  logic signed [COMPONENT_WIDTH-1:0] dir_y,
    input  logic signed [COMPONENT_WIDTH-1:0] dir_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [nvce_pkg::CHAN_W-1:0]       red,
    output logic [nvce_pkg::CHAN_W-1:0]       green,
    output logic [nvce_pkg::CHAN_W-1:0]       blue,
    output logic [nvce_pkg::CHAN_W-1:0]       alpha,
    output logic                              zero_input
);

    localparam int SW = 2 * COMPONENT_WIDTH;
    localparam int QW = SW + 16;
    localparam int NS = nvce_pkg::NUM_STEPS;

    logic                                 adv;
    logic                                 buf_full;
    logic                                 push;
    nvce_pkg::nvce_pix_t                  pix_tail;
    nvce_pkg::nvce_pix_t                  pix_head;

    // Chain of stage outputs; index 0 is the front end
    nvce_pkg::nvce_ctl_t                  ctl_chain   [0:NS];
    logic [SW-1:0]                        sumsq_chain [0:NS];
    logic [2:0][QW-1:0]                   q_chain     [0:NS];
    logic [2:0]                           neg_chain   [0:NS];
    logic [2:0][nvce_pkg::CHAN_W-1:0]     res_chain   [0:NS];

    // Whole pipeline moves unless the tail holds a result the queue cannot take
    assign adv      = !(buf_full && ctl_chain[NS].valid);
    assign in_ready = adv;
    assign push     = ctl_chain[NS].valid && adv;

    nvce_prep #(
        .COMP_W (COMPONENT_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .dir       ({dir_z, dir_y, dir_x}),
        .ctl_out   (ctl_chain[0]),
        .sumsq_out (sumsq_chain[0]),
        .q_out     (q_chain[0]),
        .neg_out   (neg_chain[0])
    );

    assign res_chain[0] = '0;

    // Binary search, most significant channel bit first
    for (genvar g = 0; g < NS; g++)
    begin : g_step
        nvce_search_step #(
            .COMP_W  (COMPONENT_WIDTH),
            .BIT_POS (NS - 1 - g)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .ctl_in    (ctl_chain[g]),
            .sumsq_in  (sumsq_chain[g]),
            .q_in      (q_chain[g]),
            .neg_in    (neg_chain[g]),
            .res_in    (res_chain[g]),
            .ctl_out   (ctl_chain[g+1]),
            .sumsq_out (sumsq_chain[g+1]),
            .q_out     (q_chain[g+1]),
            .neg_out   (neg_chain[g+1]),
            .res_out   (res_chain[g+1])
        );
    end

    // Zero vector override
    always_comb
    begin
        pix_tail.zero  = ctl_chain[NS].zero;
        pix_tail.red   = ctl_chain[NS].zero ? nvce_pkg::CHAN_MID : res_chain[NS][0];
        pix_tail.green = ctl_chain[NS].zero ? nvce_pkg::CHAN_MID : res_chain[NS][1];
        pix_tail.blue  = ctl_chain[NS].zero ? nvce_pkg::CHAN_MID : res_chain[NS][2];
    end

    nvce_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pix_in    (pix_tail),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pix_out   (pix_head)
    );

    assign red        = pix_head.red;
    assign green      = pix_head.green;
    assign blue       = pix_head.blue;
    assign zero_input = pix_head.zero;
    assign alpha      = nvce_pkg::ALPHA_FULL;

    // Zero vector leaves as mid gray
    `NVCE_ASSERT_IMP(a_zero_mid_gray, out_valid && zero_input, (red == nvce_pkg::CHAN_MID) && (green == nvce_pkg::CHAN_MID) && (blue == nvce_pkg::CHAN_MID))

    // Input stalls only with results waiting that were not taken last cycle
    `NVCE_ASSERT_IMP(a_stall_needs_backlog, !in_ready, out_valid && $past(!(out_valid && out_ready)))

    // An untaken backlog keeps the input stalled
    `NVCE_ASSERT_NEXT(a_stall_persists, !in_ready && !out_ready, !in_ready)

    // Zero flag agrees with the squared length carried to the tail
    `NVCE_ASSERT_IMP(a_zero_flag_len, ctl_chain[NS].valid, (ctl_chain[NS].zero == (sumsq_chain[NS] == '0)) && (!ctl_chain[NS].zero || (q_chain[NS] == '0)))

    // Component sign picks the channel half
    `NVCE_ASSERT_IMP(a_sign_half, ctl_chain[NS].valid && !ctl_chain[NS].zero, (neg_chain[NS][0] ? (res_chain[NS][0] <= nvce_pkg::CHAN_MID) : (res_chain[NS][0] >= nvce_pkg::CHAN_MID)) && (neg_chain[NS][1] ? (res_chain[NS][1] <= nvce_pkg::CHAN_MID) : (res_chain[NS][1] >= nvce_pkg::CHAN_MID)) && (neg_chain[NS][2] ? (res_chain[NS][2] <= nvce_pkg::CHAN_MID) : (res_chain[NS][2] >= nvce_pkg::CHAN_MID)))

endmodule

[rtl/core/nvce_prep.sv]
// Front end of the encoder: sign/magnitude split, squares, squared length
// and the 65025-scaled squared components. Three register stages. Uses nvce_pkg.
module nvce_prep #(
    parameter int COMP_W = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic [2:0][COMP_W-1:0]         dir,
    output nvce_pkg::nvce_ctl_t            ctl_out,
    output logic [2*COMP_W-1:0]            sumsq_out,
    output logic [2:0][2*COMP_W+15:0]      q_out,
    output logic [2:0]                     neg_out
);

    localparam int SW = 2 * COMP_W;
    localparam int QW = SW + 16;

    // Stage 1: sign and magnitude
    logic [2:0][COMP_W-1:0] mag1_next;
    logic [2:0]             neg1_next;
    logic [2:0][COMP_W-1:0] mag1_reg;
    logic [2:0]             neg1_reg;
    logic                   vld1_reg;

    // Stage 2: squares
    logic [2:0][SW-1:0]     sq2_next;
    logic                   zero2_next;
    logic [2:0][SW-1:0]     sq2_reg;
    logic [2:0]             neg2_reg;
    logic                   zero2_reg;
    logic                   vld2_reg;

    // Stage 3: squared length and scaled squares
    logic [SW-1:0]          sumsq3_next;
    logic [2:0][QW-1:0]     q3_next;
    logic [SW-1:0]          sumsq3_reg;
    logic [2:0][QW-1:0]     q3_reg;
    logic [2:0]             neg3_reg;
    nvce_pkg::nvce_ctl_t    ctl3_reg;

    // Two's complement magnitude; the most negative value maps to 2^(W-1)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg1_next[i] = dir[i][COMP_W-1];
            mag1_next[i] = neg1_next[i] ? (~dir[i] + COMP_W'(1)) : dir[i];
        end
    end

    // Squares of the magnitudes, zero vector detect
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq2_next[i] = mag1_reg[i] * mag1_reg[i];
        end
        zero2_next = (mag1_reg[0] == '0) && (mag1_reg[1] == '0) && (mag1_reg[2] == '0);
    end

    // 65025 * sq as (sq << 16) - (sq << 9) + sq
    always_comb
    begin
        sumsq3_next = sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            q3_next[i] = (QW'(sq2_reg[i]) << 16) - (QW'(sq2_reg[i]) << 9) + QW'(sq2_reg[i]);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            ctl3_reg <= '0;
        end
        else if (adv)
        begin
            vld1_reg       <= in_valid;
            vld2_reg       <= vld1_reg;
            ctl3_reg.valid <= vld2_reg;
            ctl3_reg.zero  <= zero2_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg   <= mag1_next;
            neg1_reg   <= neg1_next;
            sq2_reg    <= sq2_next;
            neg2_reg   <= neg1_reg;
            zero2_reg  <= zero2_next;
            sumsq3_reg <= sumsq3_next;
            q3_reg     <= q3_next;
            neg3_reg   <= neg2_reg;
        end
    end

    assign ctl_out   = ctl3_reg;
    assign sumsq_out = sumsq3_reg;
    assign q_out     = q3_reg;
    assign neg_out   = neg3_reg;

endmodule

[rtl/core/nvce_search_step.sv]
// One bit of the channel code search for all three components, three stages:
// offset square, partial products against the squared length, compare. Uses nvce_pkg.
module nvce_search_step #(
    parameter int COMP_W  = 16,
    parameter int BIT_POS = 7
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  nvce_pkg::nvce_ctl_t                    ctl_in,
    input  logic [2*COMP_W-1:0]                    sumsq_in,
    input  logic [2:0][2*COMP_W+15:0]              q_in,
    input  logic [2:0]                             neg_in,
    input  logic [2:0][nvce_pkg::CHAN_W-1:0]       res_in,
    output nvce_pkg::nvce_ctl_t                    ctl_out,
    output logic [2*COMP_W-1:0]                    sumsq_out,
    output logic [2:0][2*COMP_W+15:0]              q_out,
    output logic [2:0]                             neg_out,
    output logic [2:0][nvce_pkg::CHAN_W-1:0]       res_out
);

    localparam int SW = 2 * COMP_W;
    localparam int QW = SW + 16;
    localparam int CW = nvce_pkg::CHAN_W;
    localparam int AW = nvce_pkg::AA2_W;
    localparam int PW = AW + COMP_W;
    localparam logic [CW-1:0] TRIAL_BIT = CW'(1) << BIT_POS;

    // Stage A: trial code and squared offset |2k - 256|^2
    logic [2:0][CW-1:0]  trial_next;
    logic [2:0][CW-1:0]  dbl_next;
    logic [2:0][CW-1:0]  aa_next;
    logic [2:0][AW-1:0]  aa2_next;
    logic [2:0]          apos_next;
    nvce_pkg::nvce_ctl_t ctl_a_reg;
    logic [SW-1:0]       sumsq_a_reg;
    logic [2:0][QW-1:0]  q_a_reg;
    logic [2:0]          neg_a_reg;
    logic [2:0]          apos_a_reg;
    logic [2:0][CW-1:0]  trial_a_reg;
    logic [2:0][CW-1:0]  res_a_reg;
    logic [2:0][AW-1:0]  aa2_a_reg;

    // Stage B: aa2 * sumsq as two half-width partial products
    logic [2:0][PW-1:0]  plo_next;
    logic [2:0][PW-1:0]  phi_next;
    nvce_pkg::nvce_ctl_t ctl_b_reg;
    logic [SW-1:0]       sumsq_b_reg;
    logic [2:0][QW-1:0]  q_b_reg;
    logic [2:0]          neg_b_reg;
    logic [2:0]          apos_b_reg;
    logic [2:0][CW-1:0]  trial_b_reg;
    logic [2:0][CW-1:0]  res_b_reg;
    logic [2:0][PW-1:0]  plo_b_reg;
    logic [2:0][PW-1:0]  phi_b_reg;

    // Stage C: compare and keep or drop the trial bit
    logic [2:0][QW-1:0]  prod_c;
    logic [2:0]          fits_c;
    logic [2:0][CW-1:0]  res_next;
    nvce_pkg::nvce_ctl_t ctl_c_reg;
    logic [SW-1:0]       sumsq_c_reg;
    logic [2:0][QW-1:0]  q_c_reg;
    logic [2:0]          neg_c_reg;
    logic [2:0][CW-1:0]  res_c_reg;

    // Offset a = 2k - 256; for k >= 128 it is 2*(k-128), else 256 - 2k
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trial_next[i] = res_in[i] | TRIAL_BIT;
            dbl_next[i]   = {trial_next[i][CW-2:0], 1'b0};
            aa_next[i]    = trial_next[i][CW-1] ? dbl_next[i] : (~dbl_next[i] + CW'(1));
            aa2_next[i]   = aa_next[i] * aa_next[i];
            apos_next[i]  = trial_next[i][CW-1] && (trial_next[i][CW-2:0] != '0);
        end
    end

    // Low and high halves of the squared length
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            plo_next[i] = aa2_a_reg[i] * sumsq_a_reg[COMP_W-1:0];
            phi_next[i] = aa2_a_reg[i] * sumsq_a_reg[SW-1:COMP_W];
        end
    end

    // Keep bit when (2k - 256) * L <= 255 * |v| with the proper sign
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_c[i] = {phi_b_reg[i], {COMP_W{1'b0}}} + {{COMP_W{1'b0}}, plo_b_reg[i]};
            if (apos_b_reg[i])
            begin
                fits_c[i] = !neg_b_reg[i] && (prod_c[i] <= q_b_reg[i]);
            end
            else
            begin
                fits_c[i] = !neg_b_reg[i] || (prod_c[i] >= q_b_reg[i]);
            end
            res_next[i] = fits_c[i] ? trial_b_reg[i] : res_b_reg[i];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else if (adv)
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sumsq_a_reg <= sumsq_in;
            q_a_reg     <= q_in;
            neg_a_reg   <= neg_in;
            apos_a_reg  <= apos_next;
            trial_a_reg <= trial_next;
            res_a_reg   <= res_in;
            aa2_a_reg   <= aa2_next;

            sumsq_b_reg <= sumsq_a_reg;
            q_b_reg     <= q_a_reg;
            neg_b_reg   <= neg_a_reg;
            apos_b_reg  <= apos_a_reg;
            trial_b_reg <= trial_a_reg;
            res_b_reg   <= res_a_reg;
            plo_b_reg   <= plo_next;
            phi_b_reg   <= phi_next;

            sumsq_c_reg <= sumsq_b_reg;
            q_c_reg     <= q_b_reg;
            neg_c_reg   <= neg_b_reg;
            res_c_reg   <= res_next;
        end
    end

    assign ctl_out   = ctl_c_reg;
    assign sumsq_out = sumsq_c_reg;
    assign q_out     = q_c_reg;
    assign neg_out   = neg_c_reg;
    assign res_out   = res_c_reg;

endmodule

[rtl/core/nvce_out_buf.sv]
// Two-entry output queue that decouples the pipeline from the result ready.
// Uses nvce_pkg.
module nvce_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nvce_pkg::nvce_pix_t pix_in,
    output logic                full,
    output logic                out_valid,
    input  logic                out_ready,
    output nvce_pkg::nvce_pix_t pix_out
);

    nvce_pkg::nvce_pix_t slot_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic                pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign pix_out   = slot_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= pix_in;
        end
    end

endmodule

[sim/tb.sv]
// Self-checking testbench for normal_vector_color_encode_unit: random and directed
// direction vectors in, RGBA color codes predicted in-line and checked in order.
// Depends on nvce_pkg and the normal_vector_color_encode_unit RTL.
module tb;

    localparam int COMP_W       = 16;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 10;
    localparam int PIPE_LATENCY = 28;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int MAX_REPORTS  = 10;
    localparam longint unsigned CHAN_SCALE_SQ = 255 * 255;

    typedef struct {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } dir_req_t;

    typedef struct {
        logic [nvce_pkg::CHAN_W-1:0] red;
        logic [nvce_pkg::CHAN_W-1:0] green;
        logic [nvce_pkg::CHAN_W-1:0] blue;
        logic [nvce_pkg::CHAN_W-1:0] alpha;
        logic                        zero;
    } color_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed [COMP_W-1:0]    dir_x = '0;
    logic signed [COMP_W-1:0]    dir_y = '0;
    logic signed [COMP_W-1:0]    dir_z = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [nvce_pkg::CHAN_W-1:0] red;
    logic [nvce_pkg::CHAN_W-1:0] green;
    logic [nvce_pkg::CHAN_W-1:0] blue;
    logic [nvce_pkg::CHAN_W-1:0] alpha;
    logic                        zero_input;

    dir_req_t pending_dirs[$];
    color_t   color_expect[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       fail_count = 0;
    logic     hold_req = 1'b0;
    int       hold_left = 0;

    normal_vector_color_encode_unit #(
        .COMPONENT_WIDTH (COMP_W)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .zero_input (zero_input)
    );

    // Clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Does channel code k satisfy (2k - 256) * L <= 255 * v, with L^2 = len_sq?
    function automatic bit code_fits(int k, bit neg, longint unsigned mag,
                                     longint unsigned len_sq);
        int              off;
        longint unsigned off_mag;
        longint unsigned lhs;
        longint unsigned rhs;
        off = 2 * k - 256;
        if (off <= 0 && !neg)
            return 1'b1;
        if (off > 0 && neg)
            return 1'b0;
        off_mag = (off < 0) ? longint'(-off) : longint'(off);
        lhs = off_mag * off_mag * len_sq;
        rhs = CHAN_SCALE_SQ * mag * mag;
        return (off > 0) ? (lhs <= rhs) : (lhs >= rhs);
    endfunction

    // Binary search for the largest code that still fits
    function automatic logic [nvce_pkg::CHAN_W-1:0] channel_code(bit neg,
                                                                longint unsigned mag,
                                                                longint unsigned len_sq);
        int code;
        code = 0;
        for (int b = nvce_pkg::CHAN_W - 1; b >= 0; b--)
        begin
            if (code_fits(code | (1 << b), neg, mag, len_sq))
                code = code | (1 << b);
        end
        return code[nvce_pkg::CHAN_W-1:0];
    endfunction

    // Expected color for one direction
    function automatic color_t encode_direction(logic signed [COMP_W-1:0] x,
                                                logic signed [COMP_W-1:0] y,
                                                logic signed [COMP_W-1:0] z);
        longint          comp[3];
        longint unsigned mag[3];
        longint unsigned len_sq;
        color_t          c;
        comp[0] = x;
        comp[1] = y;
        comp[2] = z;
        len_sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (comp[i] < 0) ? longint'(-comp[i]) : longint'(comp[i]);
            len_sq += mag[i] * mag[i];
        end
        c.alpha = nvce_pkg::ALPHA_FULL;
        if (len_sq == 0)
        begin
            c.red   = nvce_pkg::CHAN_MID;
            c.green = nvce_pkg::CHAN_MID;
            c.blue  = nvce_pkg::CHAN_MID;
            c.zero  = 1'b1;
        end
        else
        begin
            c.red   = channel_code(comp[0] < 0, mag[0], len_sq);
            c.green = channel_code(comp[1] < 0, mag[1], len_sq);
            c.blue  = channel_code(comp[2] < 0, mag[2], len_sq);
            c.zero  = 1'b0;
        end
        return c;
    endfunction

    task automatic report_failure(string msg);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic signed [COMP_W-1:0] rand_comp(int span);
        return COMP_W'($urandom_range(2 * span) - span);
    endfunction

    // Component within a few steps of the positive or negative full scale
    function automatic logic signed [COMP_W-1:0] near_extreme();
        if ($urandom_range(1) != 0)
            return COMP_W'(16'sh7fff - rand_comp(2) - 2);
        return COMP_W'(16'sh8000 + rand_comp(2) + 2);
    endfunction

    // Random direction: mostly full range, some small, axis-dominant or near-extreme
    function automatic dir_req_t rand_dir();
        dir_req_t d;
        int       pick;
        int       axis;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            d.x = COMP_W'($urandom);
            d.y = COMP_W'($urandom);
            d.z = COMP_W'($urandom);
        end
        else if (pick < 75)
        begin
            d.x = rand_comp(3);
            d.y = rand_comp(3);
            d.z = rand_comp(3);
        end
        else if (pick < 90)
        begin
            // one component forced to have bit 14 set, the others small
            d.x = rand_comp(40);
            d.y = rand_comp(40);
            d.z = rand_comp(40);
            axis = $urandom_range(2);
            if (axis == 0)
                d.x = COMP_W'($urandom) | 16'h4000;
            else if (axis == 1)
                d.y = COMP_W'($urandom) | 16'h4000;
            else
                d.z = COMP_W'($urandom) | 16'h4000;
        end
        else
        begin
            d.x = near_extreme();
            d.y = near_extreme();
            d.z = near_extreme();
        end
        return d;
    endfunction

    // Driver: record accepted requests, offer the next one when the slot frees up
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        dir_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            dir_x    <= '0;
            dir_y    <= '0;
            dir_z    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                color_expect.push_back(encode_direction(dir_x, dir_y, dir_z));
            if (!in_valid || in_ready)
            begin
                if (pending_dirs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_dirs.pop_front();
                    in_valid <= 1'b1;
                    dir_x    <= nxt.x;
                    dir_y    <= nxt.y;
                    dir_z    <= nxt.z;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off counter
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: check each result against the oldest expectation, pick ready
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        color_t exp_c;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (color_expect.size() == 0)
                    report_failure($sformatf("result with nothing expected: %h %h %h %h z=%b",
                                             red, green, blue, alpha, zero_input));
                else
                begin
                    exp_c = color_expect.pop_front();
                    if (red !== exp_c.red || green !== exp_c.green || blue !== exp_c.blue ||
                        alpha !== exp_c.alpha || zero_input !== exp_c.zero)
                        report_failure($sformatf(
                            "exp rgba %h %h %h %h z=%b, got %h %h %h %h z=%b",
                            exp_c.red, exp_c.green, exp_c.blue, exp_c.alpha, exp_c.zero,
                            red, green, blue, alpha, zero_input));
                end
            end
            if (hold_left != 0)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_dir(int x, int y, int z);
        dir_req_t d;
        d.x = COMP_W'(x);
        d.y = COMP_W'(y);
        d.z = COMP_W'(z);
        pending_dirs.push_back(d);
    endtask

    task automatic push_random(int n);
        for (int i = 0; i < n; i++)
            pending_dirs.push_back(rand_dir());
    endtask

    // Sender pause: wait until every request is in and every result is out
    task automatic wait_drained();
        while (pending_dirs.size() != 0 || in_valid || color_expect.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        push_random(n);
        wait_drained();
    endtask

    // Stimulus sequence
    initial
    begin : stim_proc
        int waited;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero vector, axes, extremes, exact ties, tiny vectors
        push_dir(0, 0, 0);
        push_dir(32767, 0, 0);
        push_dir(-32768, 0, 0);
        push_dir(0, 32767, 0);
        push_dir(0, -32768, 0);
        push_dir(0, 0, 32767);
        push_dir(0, 0, -32768);
        push_dir(32767, 32767, 32767);
        push_dir(-32768, -32768, -32768);
        push_dir(32767, -32768, 1);
        push_dir(-32768, 32767, -1);
        push_dir(1, 0, 0);
        push_dir(-1, 0, 0);
        push_dir(0, 0, 5);
        push_dir(1, 1, 1);
        push_dir(-1, -1, -1);
        push_dir(1, 2, 2);
        push_dir(120, 225, 0);      // half-way rounding on red
        push_dir(-120, -225, 0);
        push_dir(8, -15, 0);
        push_dir(153, 204, 0);
        push_dir(-1, 32767, -32768);
        push_dir(0, 0, 0);
        wait_drained();

        run_phase(400, 0, 0);
        run_phase(400, 51, 0);
        run_phase(400, 0, 51);
        run_phase(300, 7, 7);

        // Back-pressure: receiver holds off while the sender keeps pushing
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_random(150);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        wait_drained();

        run_phase(100, 51, 51);

        // Let the pipeline settle, then look for leftovers
        waited = 0;
        while (color_expect.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (color_expect.size() != 0)
            report_failure($sformatf("%0d results never arrived", color_expect.size()));

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[normal_vector_color_encode_unit.f]
+incdir+rtl/core
rtl/core/nvce_pkg.sv
rtl/core/nvce_prep.sv
rtl/core/nvce_search_step.sv
rtl/core/nvce_out_buf.sv
rtl/core/normal_vector_color_encode_unit.sv
sim/tb.sv
